/* hw/rtl/bba_pkg.sv */
// Package for the bitmap block allocator: payload structs, command codes,
// sizing constants and the tail-mask helper. No dependencies.
package bba_pkg;

   localparam int ENTRY_COUNT = 4096;
   localparam int WORD_BITS   = 64;
   localparam int BIT_W       = 6;
   localparam int WORD_COUNT  = (ENTRY_COUNT + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_AW     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int IDX_W       = 12;
   localparam int FREE_W      = 13;

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_SET   = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_QUERY = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [IDX_W-1:0]   entry_index;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]   result_index;
      logic               bit_value;
      logic               full_res;
      logic [FREE_W-1:0]  free_count;
   } rsp_type;

   typedef struct packed {
      logic               found;
      logic [BIT_W-1:0]   pos;
   } penc_result_type;

   // Bits of a word that lie beyond the last entry; they count as used.
   function automatic logic [WORD_BITS-1:0] tail_mask(input logic [WORD_AW-1:0] word);
      logic [WORD_BITS-1:0] mask;
      int                   base;
      base = int'(word) * WORD_BITS;
      for (int b = 0; b < WORD_BITS; b++) begin
         mask[b] = ((base + b) >= ENTRY_COUNT);
      end
      return mask;
   endfunction

   function automatic logic [WORD_AW-1:0] word_of(input logic [IDX_W-1:0] idx);
      return WORD_AW'(idx >> BIT_W);
   endfunction

endpackage

/* hw/rtl/bitmap_block_allocator_core.sv */
// Top level of the bitmap first-fit allocator: command sequencer, bitmap
// memory with per-word valid bits, free counter and result register.
// Depends on bba_pkg, bba_ram and bba_penc.
//
//   channel   ports                          direction  payload
//   request   req_valid/req_stall/req_data   in         req_type (cmd, entry_index)
//   response  rsp_valid/rsp_stall/rsp_data   out        rsp_type (one per transaction)
//
// Set, clear and query are accepted with the memory read, modified, then
// written back with the result. Allocate reads one word per cycle from
// word 0 up to the word holding the lowest free entry, or up to the last
// word when full. Reset clears the per-word valid bits, so the bitmap
// reads as free at once. Under rsp_stall a new transaction is still
// taken; it then waits in the finish state.
module bitmap_block_allocator_core
   import bba_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BIT,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type              state_ff, state_in;
   cmd_type                cmd_ff, cmd_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [WORD_AW-1:0]     word_ff, word_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic                   wr_pend_ff, wr_pend_in;
   logic [WORD_BITS-1:0]   wdata_ff, wdata_in;
   logic [FREE_W-1:0]      cnt_ff, cnt_in;
   rsp_type                res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;
   logic [WORD_COUNT-1:0]  valid_ff, valid_in;

   logic                   rd_en;
   logic [WORD_AW-1:0]     rd_addr;
   logic                   wr_en;
   logic [WORD_BITS-1:0]   ram_rdata;
   logic [WORD_BITS-1:0]   eff_word;
   logic [WORD_BITS-1:0]   view_word;
   logic [BIT_W-1:0]       bitpos;
   logic                   in_range;
   logic                   out_free;
   penc_result_type        penc_res;

   localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(WORD_COUNT - 1);

   bba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORD_COUNT)
   ) u_bitmap_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (word_ff),
      .wr_data (wdata_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // A word never written since reset reads as all free.
   assign eff_word  = rd_valid_ff ? ram_rdata : '0;
   assign view_word = eff_word | tail_mask(word_ff);
   assign bitpos    = idx_ff[BIT_W-1:0];
   assign in_range  = (int'(idx_ff) < ENTRY_COUNT);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign wr_en     = (state_ff == ST_FINISH) && out_free && wr_pend_ff;

   bba_penc u_penc (
      .free_bits (~view_word),
      .result    (penc_res)
   );

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      word_in      = word_ff;
      rd_valid_in  = rd_valid_ff;
      wr_pend_in   = wr_pend_ff;
      wdata_in     = wdata_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      valid_in     = valid_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in      = req_data.cmd;
               idx_in      = req_data.entry_index;
               rd_en       = 1'b1;
               rd_addr     = (req_data.cmd == CMD_ALLOC) ? '0 : word_of(req_data.entry_index);
               word_in     = rd_addr;
               rd_valid_in = valid_ff[rd_addr];
               state_in    = (req_data.cmd == CMD_ALLOC) ? ST_SCAN : ST_BIT;
            end
         end
         ST_BIT: begin
            wdata_in = eff_word;
            if (cmd_ff == CMD_SET) begin
               wdata_in[bitpos] = 1'b1;
            end else if (cmd_ff == CMD_CLEAR) begin
               wdata_in[bitpos] = 1'b0;
            end
            wr_pend_in          = in_range && (cmd_ff != CMD_QUERY);
            res_in.result_index = idx_ff;
            res_in.bit_value    = in_range && eff_word[bitpos];
            res_in.full_res     = 1'b0;
            res_in.free_count   = cnt_ff;
            state_in            = ST_FINISH;
         end
         ST_SCAN: begin
            if (penc_res.found) begin
               wdata_in               = eff_word;
               wdata_in[penc_res.pos] = 1'b1;
               wr_pend_in             = 1'b1;
               cnt_in                 = (cnt_ff != '0) ? cnt_ff - 1'b1 : cnt_ff;
               res_in.result_index    = IDX_W'({word_ff, penc_res.pos});
               res_in.bit_value       = 1'b0;
               res_in.full_res        = 1'b0;
               res_in.free_count      = cnt_in;
               state_in               = ST_FINISH;
            end else if (word_ff == LAST_WORD) begin
               wr_pend_in          = 1'b0;
               res_in.result_index = '0;
               res_in.bit_value    = 1'b0;
               res_in.full_res     = 1'b1;
               res_in.free_count   = cnt_ff;
               state_in            = ST_FINISH;
            end else begin
               rd_en       = 1'b1;
               rd_addr     = word_ff + 1'b1;
               word_in     = rd_addr;
               rd_valid_in = valid_ff[rd_addr];
            end
         end
         ST_FINISH: begin
            // Write-back and result load happen together, so the next
            // transaction's read always sees the updated word.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               if (wr_pend_ff) begin
                  valid_in[word_ff] = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         cnt_ff       <= FREE_W'(ENTRY_COUNT);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         cnt_ff       <= cnt_in;
      end
      cmd_ff      <= cmd_in;
      idx_ff      <= idx_in;
      word_ff     <= word_in;
      rd_valid_ff <= rd_valid_in;
      wr_pend_ff  <= wr_pend_in;
      wdata_ff    <= wdata_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hw/rtl/bba_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/bba_penc.sv */
// Priority encoder: finds the lowest set bit of one bitmap word.
// Depends on bba_pkg.
module bba_penc
   import bba_pkg::*;
(
   input  logic [WORD_BITS-1:0] free_bits,
   output penc_result_type      result
);

   always_comb begin
      result.found = |free_bits;
      result.pos   = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (free_bits[b]) begin
            result.pos = BIT_W'(b);
         end
      end
   end

endmodule
